>>> sv/iosl_pkg.sv
// Shared types, field widths and operation codes for the ordered set list block.
package iosl_pkg;

   localparam int ENTRIES_DEF = 1024;
   localparam int MODE_W      = 3;
   localparam int ELEM_W      = 10;

   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FIRST  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd5;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd6;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ELEM_W-1:0] element;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [ELEM_W-1:0] element_out;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic exec;
      logic sweep;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_clear;
      logic sweep_last;
      logic out_free;
   } sts_type;

endpackage

>>> sv/iosl_ctrl.sv
// Controller state machine for the ordered set list block.
module iosl_ctrl
   import iosl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_SWEEP = 4'b0001,
      S_IDLE  = 4'b0010,
      S_EXEC  = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      clr_ff, clr_in;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               // A sweep started by a clear request still owes that item its result.
               state_in = clr_ff ? S_RESP : S_IDLE;
               clr_in   = 1'b0;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.req_clear) begin
                  state_in = S_SWEEP;
                  clr_in   = 1'b1;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_SWEEP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         clr_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

endmodule

>>> sv/iosl_dpath.sv
// Datapath: presence and link memories, head and tail pointers, result register.
module iosl_dpath
   import iosl_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int LINK_W = $clog2(ENTRIES + 1);
   localparam int WIDE_W = (LINK_W > ELEM_W) ? LINK_W : ELEM_W;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(ENTRIES);

   logic              pres_mem [0:ENTRIES-1];
   logic [LINK_W-1:0] next_mem [0:ENTRIES-1];
   logic [LINK_W-1:0] prev_mem [0:ENTRIES-1];

   logic              pres_rd_ff;
   logic [LINK_W-1:0] next_rd_ff, prev_rd_ff;

   logic [LINK_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [LINK_W-1:0] cnt_ff, cnt_in;
   logic [MODE_W-1:0] mode_ff;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic              valid_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   logic [WIDE_W-1:0] elem_wide;
   logic              elem_valid;
   logic [IDX_W-1:0]  rd_addr;
   logic [LINK_W-1:0] p_eff, n_eff;
   logic              ins_do, rem_do;

   logic              pres_we, pres_wd;
   logic [IDX_W-1:0]  pres_wa;
   logic              next_we, prev_we;
   logic [IDX_W-1:0]  next_wa, prev_wa;
   logic [LINK_W-1:0] next_wd, prev_wd;

   assign elem_wide  = WIDE_W'(req_data.element);
   assign elem_valid = elem_wide < WIDE_W'(ENTRIES);
   assign rd_addr    = (req_data.mode == MODE_POP) ? head_ff[IDX_W-1:0]
                                                   : elem_wide[IDX_W-1:0];
   assign cur_in     = (req_data.mode == MODE_POP || req_data.mode == MODE_FIRST)
                       ? head_ff : elem_wide[LINK_W-1:0];

   // The head's predecessor and the tail's successor are never read from memory; they
   // follow from the pointers, so an insert touches each link memory once.
   assign p_eff = (cur_ff == head_ff) ? NIL : prev_rd_ff;
   assign n_eff = (cur_ff == tail_ff) ? NIL : next_rd_ff;

   assign ins_do = cmd.exec && mode_ff == MODE_INSERT && valid_ff && !pres_rd_ff;
   assign rem_do = cmd.exec &&
                   ((mode_ff == MODE_REMOVE && valid_ff && pres_rd_ff) ||
                    (mode_ff == MODE_POP && cur_ff < NIL));

   always_comb begin
      pres_we = 1'b0;
      pres_wd = 1'b0;
      pres_wa = cur_ff[IDX_W-1:0];
      next_we = 1'b0;
      next_wa = tail_ff[IDX_W-1:0];
      next_wd = cur_ff;
      prev_we = 1'b0;
      prev_wa = cur_ff[IDX_W-1:0];
      prev_wd = tail_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      if (cmd.sweep) begin
         pres_we = 1'b1;
         pres_wa = cnt_ff[IDX_W-1:0];
         head_in = NIL;
         tail_in = NIL;
         cnt_in  = sts.sweep_last ? '0 : cnt_ff + 1'b1;
      end else if (ins_do) begin
         pres_we = 1'b1;
         pres_wd = 1'b1;
         prev_we = 1'b1;
         next_we = tail_ff < NIL;
         if (tail_ff == NIL) begin
            head_in = cur_ff;
         end
         tail_in = cur_ff;
      end else if (rem_do) begin
         pres_we = 1'b1;
         next_we = p_eff < NIL;
         next_wa = p_eff[IDX_W-1:0];
         next_wd = n_eff;
         prev_we = n_eff < NIL;
         prev_wa = n_eff[IDX_W-1:0];
         prev_wd = p_eff;
         if (p_eff == NIL) begin
            head_in = n_eff;
         end
         if (n_eff == NIL) begin
            tail_in = p_eff;
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      case (mode_ff) inside
         MODE_INSERT: begin
            rsp_in.ok = valid_ff && !pres_rd_ff;
         end
         MODE_REMOVE, MODE_QUERY: begin
            rsp_in.ok = valid_ff && pres_rd_ff;
         end
         MODE_POP, MODE_FIRST: begin
            if (cur_ff < NIL) begin
               rsp_in.ok          = 1'b1;
               rsp_in.element_out = ELEM_W'(cur_ff);
            end
         end
         MODE_NEXT: begin
            if (valid_ff && pres_rd_ff && n_eff < NIL) begin
               rsp_in.ok          = 1'b1;
               rsp_in.element_out = ELEM_W'(n_eff);
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pres_we) begin
         pres_mem[pres_wa] <= pres_wd;
      end
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (cmd.accept) begin
         pres_rd_ff <= pres_mem[rd_addr];
         next_rd_ff <= next_mem[rd_addr];
         prev_rd_ff <= prev_mem[rd_addr];
         mode_ff    <= req_data.mode;
         cur_ff     <= cur_in;
         valid_ff   <= elem_valid;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= NIL;
         tail_ff      <= NIL;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.req_clear  = req_data.mode == MODE_CLEAR;
   assign sts.sweep_last = cnt_ff == LINK_W'(ENTRIES - 1);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> sv/indexed_ordered_set_list_top.sv
// Insertion-ordered set of element indices kept as a doubly linked list.
// The result of every request but clear is registered in the execute state, or later
// in the response state while the output is stalled. No new item is taken until then,
// as an element's links are read on acceptance and its neighbours' links then written.
// Clear sweeps the presence memory, one entry a cycle, and then returns its result.
// Reset runs the same sweep with req_ready low throughout.
module indexed_ordered_set_list_top
   import iosl_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   iosl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   iosl_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Only one item is in flight at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another item is in flight");

   // A new result only appears after the block has stopped taking requests.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without an item being worked on");

   // A clear holds off requests for its sweep.
   a_clear_sweeps: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.mode == MODE_CLEAR) |=> ##1 !req_ready)
      else $error("request taken during clear sweep");

   // A failed operation reports no element.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |-> (rsp_data.element_out == '0))
      else $error("element reported on a failed operation");

endmodule

>>> sim/tb_indexed_ordered_set_list_top.sv
// Self-checking testbench for the insertion-ordered set list block.
`timescale 1ns / 100ps

module tb_indexed_ordered_set_list_top;
   import iosl_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
   localparam logic [10:0] NIL_CODE = 11'(ENTRIES_DEF);
   localparam int WATCHDOG_LIMIT = 8000;
   localparam int REPORT_CAP = 60;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   indexed_ordered_set_list_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Predicted contents of the set.
   bit          set_member [ENTRIES_DEF];
   logic [10:0] succ_link  [ENTRIES_DEF];
   logic [10:0] pred_link  [ENTRIES_DEF];
   logic [10:0] list_head = NIL_CODE;
   logic [10:0] list_tail = NIL_CODE;

   rsp_type           pending_results [$];
   logic [ELEM_W-1:0] elem_pool [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int failures = 0;
   int items_sent = 0;
   int results_seen = 0;
   int ok_results = 0;
   int clears_sent = 0;
   int idle_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void unlink_member(input logic [ELEM_W-1:0] e);
      logic [10:0] p;
      logic [10:0] n;
      p = pred_link[e];
      n = succ_link[e];
      if (p != NIL_CODE) succ_link[p[ELEM_W-1:0]] = n;
      else list_head = n;
      if (n != NIL_CODE) pred_link[n[ELEM_W-1:0]] = p;
      else list_tail = p;
      set_member[e] = 1'b0;
   endfunction

   function automatic rsp_type apply_set_op(input req_type item);
      rsp_type           res;
      logic [ELEM_W-1:0] e;
      res = '0;
      e = item.element;
      case (item.mode)
         MODE_INSERT: begin
            if (!set_member[e]) begin
               set_member[e] = 1'b1;
               pred_link[e] = list_tail;
               succ_link[e] = NIL_CODE;
               if (list_tail != NIL_CODE) succ_link[list_tail[ELEM_W-1:0]] = {1'b0, e};
               else list_head = {1'b0, e};
               list_tail = {1'b0, e};
               res.ok = 1'b1;
            end
         end
         MODE_REMOVE: begin
            if (set_member[e]) begin
               unlink_member(e);
               res.ok = 1'b1;
            end
         end
         MODE_POP: begin
            if (list_head != NIL_CODE) begin
               res.element_out = list_head[ELEM_W-1:0];
               unlink_member(list_head[ELEM_W-1:0]);
               res.ok = 1'b1;
            end
         end
         MODE_QUERY: begin
            res.ok = set_member[e];
         end
         MODE_FIRST: begin
            if (list_head != NIL_CODE) begin
               res.element_out = list_head[ELEM_W-1:0];
               res.ok = 1'b1;
            end
         end
         MODE_NEXT: begin
            if (set_member[e] && succ_link[e] != NIL_CODE) begin
               res.element_out = succ_link[e][ELEM_W-1:0];
               res.ok = 1'b1;
            end
         end
         MODE_CLEAR: begin
            foreach (set_member[i]) set_member[i] = 1'b0;
            list_head = NIL_CODE;
            list_tail = NIL_CODE;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Results are checked before the item accepted at the same edge is predicted.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_data.ok === 1'b1) ok_results++;
            if (pending_results.size() == 0) begin
               failures++;
               if (failures <= REPORT_CAP) $error("result arrived with no item outstanding");
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.ok !== want.ok) begin
                  failures++;
                  if (failures <= REPORT_CAP)
                     $error("ok: expected %0d, got %0d", want.ok, rsp_data.ok);
               end
               if (rsp_data.element_out !== want.element_out) begin
                  failures++;
                  if (failures <= REPORT_CAP)
                     $error("element_out: expected %0d, got %0d",
                            want.element_out, rsp_data.element_out);
               end
            end
         end
         if (req_valid && req_ready) begin
            items_sent++;
            if (req_data.mode == MODE_CLEAR) clears_sent++;
            pending_results.push_back(apply_set_op(req_data));
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[indexed_ordered_set_list_top] ERROR");
         $finish;
      end
   end

   // Valid stays high between back-to-back items and is only lowered for a gap.
   task automatic send_item(input req_type item);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_op(input logic [MODE_W-1:0] mode, input logic [ELEM_W-1:0] e);
      req_type item;
      item.mode = mode;
      item.element = e;
      send_item(item);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic refill_pool(input int n);
      elem_pool.delete();
      repeat (n) elem_pool.push_back(ELEM_W'($urandom_range(0, ENTRIES_DEF - 1)));
   endtask

   function automatic req_type random_request();
      req_type item;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)      item.mode = MODE_INSERT;
      else if (pick < 45) item.mode = MODE_REMOVE;
      else if (pick < 55) item.mode = MODE_POP;
      else if (pick < 70) item.mode = MODE_QUERY;
      else if (pick < 75) item.mode = MODE_FIRST;
      else if (pick < 96) item.mode = MODE_NEXT;
      else if (pick < 98) item.mode = MODE_UNUSED;
      else                item.mode = MODE_CLEAR;
      if ($urandom_range(0, 9) == 0)
         item.element = ELEM_W'($urandom_range(0, ENTRIES_DEF - 1));
      else
         item.element = elem_pool[$urandom_range(0, elem_pool.size() - 1)];
      return item;
   endfunction

   task automatic test_empty_set();
      send_op(MODE_FIRST, 10'd0);
      send_op(MODE_POP, 10'h3FF);
      send_op(MODE_QUERY, 10'd0);
      send_op(MODE_NEXT, 10'h3FF);
      send_op(MODE_REMOVE, 10'd5);
      send_op(MODE_UNUSED, 10'h3FF);
   endtask

   task automatic test_insert_remove();
      send_op(MODE_INSERT, 10'd0);
      send_op(MODE_INSERT, 10'h3FF);
      send_op(MODE_INSERT, 10'd0);
      send_op(MODE_INSERT, 10'h155);
      send_op(MODE_INSERT, 10'h2AA);
      send_op(MODE_QUERY, 10'h3FF);
      send_op(MODE_QUERY, 10'h155);
      // Unlinking from the middle of the list, then again once absent.
      send_op(MODE_REMOVE, 10'h3FF);
      send_op(MODE_REMOVE, 10'h3FF);
      send_op(MODE_NEXT, 10'd0);
      send_op(MODE_NEXT, 10'h2AA);
      send_op(MODE_POP, 10'd0);
      send_op(MODE_FIRST, 10'd0);
   endtask

   task automatic test_clear();
      send_op(MODE_CLEAR, 10'h2AA);
      send_op(MODE_QUERY, 10'h155);
      send_op(MODE_FIRST, 10'd0);
      send_op(MODE_INSERT, 10'd7);
      send_op(MODE_FIRST, 10'd0);
   endtask

   // Grows the list, follows it from the head with next requests, then pops from the head.
   task automatic test_list_walk(input int n_ins);
      logic [10:0]       cur;
      logic [ELEM_W-1:0] chain [$];
      repeat (n_ins) send_op(MODE_INSERT, ELEM_W'($urandom_range(0, ENTRIES_DEF - 1)));
      wait_drained();
      cur = list_head;
      while (cur != NIL_CODE && chain.size() < 40) begin
         chain.push_back(cur[ELEM_W-1:0]);
         cur = succ_link[cur[ELEM_W-1:0]];
      end
      send_op(MODE_FIRST, 10'd0);
      foreach (chain[i]) send_op(MODE_NEXT, chain[i]);
      repeat (3) send_op(MODE_POP, 10'd0);
   endtask

   task automatic test_random_traffic(input int send_pct, input int stall_pct, input int n_items);
      int sizes [4];
      sizes = '{4, 16, 64, 256};
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < n_items; i++) begin
         if (i % 50 == 0) refill_pool(sizes[$urandom_range(0, 3)]);
         if (i == n_items / 2) test_list_walk(24);
         send_item(random_request());
      end
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_empty_set();
      test_insert_remove();
      test_clear();
      wait_drained();
      test_random_traffic(0, 0, 240);
      test_random_traffic(52, 0, 240);
      test_random_traffic(0, 52, 240);
      test_random_traffic(12, 12, 240);
      wait_drained();
      repeat (8) @(posedge clock);
      $display("Run covered %0d items, %0d clears, %0d results checked (%0d with ok set),",
               items_sent, clears_sent, results_seen, ok_results);
      $display("under no idling, sender gaps, receiver stalls and both together.");
      if (failures == 0) begin
         $display("[indexed_ordered_set_list_top] OK");
      end else begin
         $display("[indexed_ordered_set_list_top] ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
sv/iosl_pkg.sv
sv/iosl_ctrl.sv
sv/iosl_dpath.sv
sv/indexed_ordered_set_list_top.sv
sim/tb_indexed_ordered_set_list_top.sv
